/* rtl/ldm_pkg.sv */
// Shared types, constants and saturation helpers of the lens distortion mapper.
package ldm_pkg;

   localparam int COORD_BITS = 12;
   localparam int FRAC_BITS  = 28;
   localparam int MUL_LAT    = 7;
   localparam int DIV_BITS   = 33 + FRAC_BITS;

   localparam logic signed [63:0] LIM_VAL = 64'sh0FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] ONE_VAL = 64'sh0000_0000_1000_0000;

   typedef enum logic [2:0] {
      REG_FOCAL_X    = 3'd0,
      REG_FOCAL_Y    = 3'd1,
      REG_CENTER     = 3'd2,
      REG_K1         = 3'd3,
      REG_K2         = 3'd4,
      REG_K3         = 3'd5,
      REG_TANGENTIAL = 3'd6,
      REG_MODEL      = 3'd7
   } reg_idx_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
   } req_type;

   typedef struct packed {
      logic signed [15:0] mapped_x;
      logic signed [15:0] mapped_y;
      logic               saturated;
   } rsp_type;

   function automatic logic sat_hit(input logic signed [63:0] v);
      return (v > LIM_VAL) || (v < -LIM_VAL);
   endfunction

   function automatic logic signed [63:0] sat_val(input logic signed [63:0] v);
      if (v > LIM_VAL) begin
         return LIM_VAL;
      end else if (v < -LIM_VAL) begin
         return -LIM_VAL;
      end else begin
         return v;
      end
   endfunction

endpackage

/* rtl/ldm_mul.sv */
// Pipelined signed fixed-point multiplier with Q.28 rescale and magnitude clamp.
module ldm_mul import ldm_pkg::*; (
   input  logic               clock,
   input  logic signed [63:0] a,
   input  logic signed [63:0] b,
   output logic signed [63:0] p,
   output logic               clip
);

   logic [63:0]  ua_ff [1:4];
   logic [63:0]  ub_ff [1:4];
   logic [6:1]   neg_ff;
   logic [63:0]  pr2_ff, pr3_ff, pr4_ff, pr5_ff;
   logic [127:0] acc3_ff, acc4_ff, acc5_ff, acc6_ff;
   logic [63:0]  rs_in, mag_in;
   logic         ovf_in;
   logic signed [63:0] p_ff;
   logic         clip_ff;

   always_comb begin
      rs_in  = acc6_ff[FRAC_BITS+63:FRAC_BITS];
      ovf_in = (|acc6_ff[127:FRAC_BITS+64]) || (rs_in > 64'(LIM_VAL));
      mag_in = ovf_in ? 64'(LIM_VAL) : rs_in;
   end

   always_ff @(posedge clock) begin
      ua_ff[1]  <= a[63] ? 64'(-a) : 64'(a);
      ub_ff[1]  <= b[63] ? 64'(-b) : 64'(b);
      neg_ff[1] <= a[63] ^ b[63];
      for (int i = 2; i <= 4; i++) begin
         ua_ff[i] <= ua_ff[i-1];
         ub_ff[i] <= ub_ff[i-1];
      end
      for (int i = 2; i <= 6; i++) begin
         neg_ff[i] <= neg_ff[i-1];
      end
      pr2_ff  <= ua_ff[1][31:0] * ub_ff[1][31:0];
      acc3_ff <= {64'b0, pr2_ff};
      pr3_ff  <= ua_ff[2][31:0] * ub_ff[2][63:32];
      acc4_ff <= acc3_ff + {32'b0, pr3_ff, 32'b0};
      pr4_ff  <= ua_ff[3][63:32] * ub_ff[3][31:0];
      acc5_ff <= acc4_ff + {32'b0, pr4_ff, 32'b0};
      pr5_ff  <= ua_ff[4][63:32] * ub_ff[4][63:32];
      acc6_ff <= acc5_ff + {pr5_ff, 64'b0};
      p_ff    <= neg_ff[6] ? -$signed(mag_in) : $signed(mag_in);
      clip_ff <= ovf_in;
   end

   assign p    = p_ff;
   assign clip = clip_ff;

endmodule

/* rtl/lens_distortion_mapper.sv */
// Top level of the lens distortion mapper: register file, divider and multiplier pipeline.
//
//   channel   ports                               beat taken when
//   request   start, busy, req_data               start high and busy low
//   response  rsp_valid, rsp_data                 rsp_valid high, one cycle
//   registers psel, penable, pwrite, paddr, ...   psel, penable, pwrite, pready high
//
// One beat enters per clock, since the pipeline never stalls.
// The datapath holds the 61-stage restoring divider and eight 7-stage multiplier ranks.
// busy stays low, so a request can be taken every cycle. Reset clears the valid pipeline
// and returns every register-file register to its reset value.
// The receiver cannot hold results off, so the pipeline never stalls.
module lens_distortion_mapper import ldm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  req_type       req_data,
   output logic          rsp_valid,
   output rsp_type       rsp_data,
   input  logic          psel,
   input  logic          penable,
   input  logic          pwrite,
   input  logic [5:0]    paddr,
   input  logic [63:0]   pwdata,
   output logic [63:0]   prdata,
   output logic          pready
);

   localparam int L  = MUL_LAT;
   localparam int T0 = DIV_BITS + 2;
   localparam int T1 = T0 + L + 1;
   localparam int T2 = T1 + 3 * L + 1;
   localparam int T3 = T2 + L;
   localparam int T4 = T3 + L + 1;
   localparam int T5 = T4 + L + 1;
   localparam int T6 = T5 + L + 1;

   localparam int M_XX = 0,  M_YY = 1,  M_R4 = 2,  M_K1 = 3,  M_R6 = 4,  M_K2 = 5;
   localparam int M_K3 = 6,  M_XS = 7,  M_YS = 8,  M_TXY = 9, M_TXX = 10, M_TYY = 11;
   localparam int M_P1T = 12, M_P2R = 13, M_P2T = 14, M_P1R = 15, M_DX = 16, M_DY = 17;
   localparam int NMUL = 18;

   logic [31:0] focal_x_ff, focal_y_ff, k1_ff, k2_ff, k3_ff;
   logic [63:0] center_ff, tang_ff;
   logic        model_ff;
   logic        wr_in;

   logic [31:0]        fsel [2];
   logic [31:0]        cen  [2];
   logic signed [63:0] k1, k2, k3, p1, p2;

   logic               accept;
   logic [T6:1]        vld_ff;
   logic signed [63:0] diff_in [2];
   logic [DIV_BITS-1:0] num_in [2];

   logic [DIV_BITS-1:0] dnq_ff  [2][1:DIV_BITS+1];
   logic [31:0]         drem_ff [2][1:DIV_BITS+1];
   logic                dneg_ff [2][1:DIV_BITS+1];
   logic [32:0]         dtry    [2][2:DIV_BITS+1];
   logic                dge     [2][2:DIV_BITS+1];
   logic [31:0]         drem_in [2][2:DIV_BITS+1];

   logic [DIV_BITS-1:0] q_in  [2];
   logic signed [63:0]  qm_in [2];
   logic signed [63:0]  nd_ff [2][T0:T3];

   logic signed [63:0] ma [NMUL];
   logic signed [63:0] mb [NMUL];
   logic signed [63:0] mp [NMUL];
   logic               mc [NMUL];

   logic signed [63:0] r2_ff  [T1:T4-1];
   logic signed [63:0] kd1_ff [1:2*L];
   logic signed [63:0] kd2_ff [1:L];
   logic signed [63:0] xsd_ff [1:2*L+1];
   logic signed [63:0] ysd_ff [1:2*L+1];
   logic signed [63:0] f_ff, txy2_ff, rx_ff, ry_ff, dx_ff, dy_ff;
   logic signed [63:0] tx, ty;
   logic signed [63:0] r2_in, f_in, rx_in, ry_in, dx_in, dy_in;
   logic signed [63:0] vx_in, vy_in, tvx_in, tvy_in;
   logic signed [15:0] mx_in, my_in, mx_ff, my_ff;
   logic               ox_in, oy_in;
   logic [T6:T0]       cl_ff;
   logic [T6:T0+1]     ev;

   // Register file.
   assign wr_in  = psel && penable && pwrite && pready;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff <= 32'h0001_0000;
         focal_y_ff <= 32'h0001_0000;
         center_ff  <= '0;
         k1_ff      <= '0;
         k2_ff      <= '0;
         k3_ff      <= '0;
         tang_ff    <= '0;
         model_ff   <= 1'b0;
      end else if (wr_in) begin
         case (reg_idx_type'(paddr[5:3]))
            REG_FOCAL_X:    focal_x_ff <= pwdata[31:0];
            REG_FOCAL_Y:    focal_y_ff <= pwdata[31:0];
            REG_CENTER:     center_ff  <= pwdata;
            REG_K1:         k1_ff      <= pwdata[31:0];
            REG_K2:         k2_ff      <= pwdata[31:0];
            REG_K3:         k3_ff      <= pwdata[31:0];
            REG_TANGENTIAL: tang_ff    <= pwdata;
            REG_MODEL:      model_ff   <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx_type'(paddr[5:3]))
         REG_FOCAL_X:    prdata = {32'b0, focal_x_ff};
         REG_FOCAL_Y:    prdata = {32'b0, focal_y_ff};
         REG_CENTER:     prdata = center_ff;
         REG_K1:         prdata = {32'b0, k1_ff};
         REG_K2:         prdata = {32'b0, k2_ff};
         REG_K3:         prdata = {32'b0, k3_ff};
         REG_TANGENTIAL: prdata = tang_ff;
         REG_MODEL:      prdata = {63'b0, model_ff};
         default:        prdata = '0;
      endcase
   end

   assign fsel[0] = (focal_x_ff == 32'd0) ? 32'd1 : focal_x_ff;
   assign fsel[1] = (focal_y_ff == 32'd0) ? 32'd1 : focal_y_ff;
   assign cen[0]  = center_ff[31:0];
   assign cen[1]  = center_ff[63:32];
   assign k1 = {{32{k1_ff[31]}}, k1_ff};
   assign k2 = {{32{k2_ff[31]}}, k2_ff};
   assign k3 = {{32{k3_ff[31]}}, k3_ff};
   assign p1 = {{32{tang_ff[31]}}, tang_ff[31:0]};
   assign p2 = {{32{tang_ff[63]}}, tang_ff[63:32]};

   // Request side and valid pipeline.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[T6-1:1], accept};
      end
   end

   // Normalization: restoring divider, one quotient bit per stage.
   always_comb begin
      diff_in[0] = $signed(64'(req_data.pixel_x) << 16) - $signed({32'b0, cen[0]});
      diff_in[1] = $signed(64'(req_data.pixel_y) << 16) - $signed({32'b0, cen[1]});
      for (int l = 0; l < 2; l++) begin
         num_in[l] = diff_in[l][63] ? {33'(-diff_in[l]), 28'b0} : {diff_in[l][32:0], 28'b0};
         for (int k = 2; k <= DIV_BITS + 1; k++) begin
            dtry[l][k]    = {drem_ff[l][k-1], dnq_ff[l][k-1][DIV_BITS-1]};
            dge[l][k]     = dtry[l][k] >= {1'b0, fsel[l]};
            drem_in[l][k] = dge[l][k] ? 32'(dtry[l][k] - {1'b0, fsel[l]}) : dtry[l][k][31:0];
         end
         q_in[l]  = dnq_ff[l][DIV_BITS+1];
         qm_in[l] = q_in[l][DIV_BITS-1] ? LIM_VAL : $signed({3'b0, q_in[l]});
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < 2; l++) begin
         dnq_ff[l][1]  <= num_in[l];
         drem_ff[l][1] <= '0;
         dneg_ff[l][1] <= diff_in[l][63];
         for (int k = 2; k <= DIV_BITS + 1; k++) begin
            dnq_ff[l][k]  <= {dnq_ff[l][k-1][DIV_BITS-2:0], dge[l][k]};
            drem_ff[l][k] <= drem_in[l][k];
            dneg_ff[l][k] <= dneg_ff[l][k-1];
         end
         nd_ff[l][T0] <= dneg_ff[l][DIV_BITS+1] ? -qm_in[l] : qm_in[l];
         for (int k = T0 + 1; k <= T3; k++) begin
            nd_ff[l][k] <= nd_ff[l][k-1];
         end
      end
   end

   // Multiplier ranks.
   assign tx = model_ff ? nd_ff[0][T3] : mp[M_XS];
   assign ty = model_ff ? nd_ff[1][T3] : mp[M_YS];

   always_comb begin
      ma[M_XX]  = nd_ff[0][T0];  mb[M_XX]  = nd_ff[0][T0];
      ma[M_YY]  = nd_ff[1][T0];  mb[M_YY]  = nd_ff[1][T0];
      ma[M_R4]  = r2_ff[T1];     mb[M_R4]  = r2_ff[T1];
      ma[M_K1]  = k1;            mb[M_K1]  = r2_ff[T1];
      ma[M_R6]  = mp[M_R4];      mb[M_R6]  = r2_ff[T1+L];
      ma[M_K2]  = k2;            mb[M_K2]  = mp[M_R4];
      ma[M_K3]  = k3;            mb[M_K3]  = mp[M_R6];
      ma[M_XS]  = nd_ff[0][T2];  mb[M_XS]  = f_ff;
      ma[M_YS]  = nd_ff[1][T2];  mb[M_YS]  = f_ff;
      ma[M_TXY] = tx;            mb[M_TXY] = ty;
      ma[M_TXX] = tx;            mb[M_TXX] = tx;
      ma[M_TYY] = ty;            mb[M_TYY] = ty;
      ma[M_P1T] = p1;            mb[M_P1T] = txy2_ff;
      ma[M_P2R] = p2;            mb[M_P2R] = rx_ff;
      ma[M_P2T] = p2;            mb[M_P2T] = txy2_ff;
      ma[M_P1R] = p1;            mb[M_P1R] = ry_ff;
      ma[M_DX]  = dx_ff;         mb[M_DX]  = $signed({32'b0, fsel[0]});
      ma[M_DY]  = dy_ff;         mb[M_DY]  = $signed({32'b0, fsel[1]});
   end

   for (genvar g = 0; g < NMUL; g++) begin : g_mul
      ldm_mul u_mul (
         .clock (clock),
         .a     (ma[g]),
         .b     (mb[g]),
         .p     (mp[g]),
         .clip  (mc[g])
      );
   end

   // Sums, clamps and denormalization.
   always_comb begin
      r2_in  = mp[M_XX] + mp[M_YY];
      f_in   = ONE_VAL + kd1_ff[2*L] + kd2_ff[L] + mp[M_K3];
      rx_in  = r2_ff[T4-1] + (mp[M_TXX] <<< 1);
      ry_in  = r2_ff[T4-1] + (mp[M_TYY] <<< 1);
      dx_in  = xsd_ff[2*L+1] + mp[M_P1T] + mp[M_P2R];
      dy_in  = ysd_ff[2*L+1] + mp[M_P2T] + mp[M_P1R];
      vx_in  = mp[M_DX] + $signed({32'b0, cen[0]});
      vy_in  = mp[M_DY] + $signed({32'b0, cen[1]});
      tvx_in = (vx_in + (vx_in[63] ? 64'sd65535 : 64'sd0)) >>> 16;
      tvy_in = (vy_in + (vy_in[63] ? 64'sd65535 : 64'sd0)) >>> 16;
      ox_in  = (tvx_in > 64'sd32767) || (tvx_in < -64'sd32768);
      oy_in  = (tvy_in > 64'sd32767) || (tvy_in < -64'sd32768);
      mx_in  = (tvx_in > 64'sd32767) ? 16'sh7FFF :
               (tvx_in < -64'sd32768) ? 16'sh8000 : tvx_in[15:0];
      my_in  = (tvy_in > 64'sd32767) ? 16'sh7FFF :
               (tvy_in < -64'sd32768) ? 16'sh8000 : tvy_in[15:0];

      ev = '0;
      ev[T1]       = mc[M_XX] | mc[M_YY] | sat_hit(r2_in);
      ev[T1+L+1]   = mc[M_R4] | mc[M_K1];
      ev[T1+2*L+1] = mc[M_R6] | mc[M_K2];
      ev[T2]       = mc[M_K3] | sat_hit(f_in);
      ev[T3+1]     = mc[M_XS] | mc[M_YS];
      ev[T4]       = mc[M_TXY] | mc[M_TXX] | mc[M_TYY] | sat_hit(rx_in) | sat_hit(ry_in);
      ev[T5]       = mc[M_P1T] | mc[M_P2R] | mc[M_P2T] | mc[M_P1R]
                     | sat_hit(dx_in) | sat_hit(dy_in);
      ev[T6]       = mc[M_DX] | mc[M_DY] | ox_in | oy_in;
   end

   always_ff @(posedge clock) begin
      r2_ff[T1] <= sat_val(r2_in);
      for (int k = T1 + 1; k <= T4 - 1; k++) begin
         r2_ff[k] <= r2_ff[k-1];
      end
      kd1_ff[1] <= mp[M_K1];
      for (int k = 2; k <= 2 * L; k++) begin
         kd1_ff[k] <= kd1_ff[k-1];
      end
      kd2_ff[1] <= mp[M_K2];
      for (int k = 2; k <= L; k++) begin
         kd2_ff[k] <= kd2_ff[k-1];
      end
      xsd_ff[1] <= mp[M_XS];
      ysd_ff[1] <= mp[M_YS];
      for (int k = 2; k <= 2 * L + 1; k++) begin
         xsd_ff[k] <= xsd_ff[k-1];
         ysd_ff[k] <= ysd_ff[k-1];
      end
      f_ff    <= sat_val(f_in);
      txy2_ff <= mp[M_TXY] <<< 1;
      rx_ff   <= sat_val(rx_in);
      ry_ff   <= sat_val(ry_in);
      dx_ff   <= sat_val(dx_in);
      dy_ff   <= sat_val(dy_in);
      mx_ff   <= mx_in;
      my_ff   <= my_in;
      cl_ff[T0] <= q_in[0][DIV_BITS-1] | q_in[1][DIV_BITS-1];
      for (int k = T0 + 1; k <= T6; k++) begin
         cl_ff[k] <= cl_ff[k-1] | ev[k];
      end
   end

   assign rsp_valid          = vld_ff[T6];
   assign rsp_data.mapped_x  = mx_ff;
   assign rsp_data.mapped_y  = my_ff;
   assign rsp_data.saturated = cl_ff[T6];

endmodule
